/* rtl/s2dh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package s2dh_pkg;

	localparam int MAX_BINS    = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int IDX_W       = $clog2(MAX_BINS);
	localparam int ADDR_W      = 2 * IDX_W;
	localparam int DEPTH       = MAX_BINS * MAX_BINS;
	localparam int OPN_W       = 16;
	localparam int SCALE_W     = 15;
	localparam int BINS_W      = 5;
	localparam int CFG_W       = 15;
	localparam int FRAC_W      = COUNT_WIDTH + 1;
	localparam int QDEPTH      = 2;

	localparam logic [SCALE_W-1:0] SCALE_RST = 15'd2560;
	localparam logic [BINS_W-1:0]  BINS_RST  = 5'd10;

	localparam logic CFG_SCALE = 1'b0;
	localparam logic CFG_BINS  = 1'b1;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t            op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_DIV,
		F_PUSH
	} fstate_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RD,
		B_DIV,
		B_DONE
	} bstate_t;

endpackage

`default_nettype wire

/* rtl/scaled_2d_histogram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-dimensional histogram of paired Q7.8 opinions over a 16 by 16 store of
// saturating 16-bit counts. The front takes one item at a time: a sample goes
// through operand add, bin scaling multiply, four restoring quotient steps and
// hand-off there, other modes straight to hand-off. A two-entry command queue
// follows; the back reads the bin from its RAM, updates it, then runs a
// bit-serial 17-step divider for the Q1.16 fraction, and takes the next command
// only when it is through with the last. The result sits in an output register,
// so the back goes on with the next command while a result waits. A clear takes
// effect through per-bin valid bits; there is no clearing pass.
// Configuration writes are taken at once and must come while the block is idle.

module scaled_2d_histogram (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [s2dh_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        mode,
	input  wire logic signed [s2dh_pkg::OPN_W-1:0] opinion_x,
	input  wire logic signed [s2dh_pkg::OPN_W-1:0] opinion_y,
	input  wire logic [3:0]                        read_row,
	input  wire logic [3:0]                        read_col,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [3:0]                             bin_row,
	output logic [3:0]                             bin_col,
	output logic [15:0]                            bin_count,
	output logic [15:0]                            agent_total,
	output logic [16:0]                            fraction
);

	import s2dh_pkg::*;

	cmd_t push_data, pop_data;
	logic push_valid, push_ready, pop_valid, pop_ready;

	s2dh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.opinion_x(opinion_x),
		.opinion_y(opinion_y),
		.read_row (read_row),
		.read_col (read_col),
		.cmd      (push_data),
		.cmd_valid(push_valid),
		.cmd_ready(push_ready)
	);

	s2dh_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_data (push_data),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready)
	);

	s2dh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (pop_data),
		.cmd_valid  (pop_valid),
		.cmd_ready  (pop_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bin_row    (bin_row),
		.bin_col    (bin_col),
		.bin_count  (bin_count),
		.agent_total(agent_total),
		.fraction   (fraction)
	);

endmodule

`default_nettype wire

/* rtl/s2dh_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module s2dh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/s2dh_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module s2dh_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [s2dh_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    mode,
	input  wire logic signed [s2dh_pkg::OPN_W-1:0] opinion_x,
	input  wire logic signed [s2dh_pkg::OPN_W-1:0] opinion_y,
	input  wire logic [3:0]                    read_row,
	input  wire logic [3:0]                    read_col,
	output s2dh_pkg::cmd_t                     cmd,
	output logic                               cmd_valid,
	input  wire logic                          cmd_ready
);

	import s2dh_pkg::*;

	localparam int NUM_W = OPN_W + 2;
	localparam int REM_W = OPN_W + 1 + BINS_W;
	localparam int CNT_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;

	fstate_t state_q, state_d;

	logic [SCALE_W-1:0] scale_q;
	logic [BINS_W-1:0]  bins_q;
	logic [SCALE_W-1:0] s_eff;
	logic [BINS_W-1:0]  bins_eff;
	logic [SCALE_W:0]   div_d;
	logic [IDX_W-1:0]   bmax;

	mode_t              op_q;
	logic [IDX_W-1:0]   row_q, col_q;
	logic [NUM_W-1:0]   num_q [2];
	logic [REM_W-1:0]   rem_q [2];
	logic [IDX_W-1:0]   quo_q [2];
	logic               neg_q [2];
	logic               hi_q  [2];
	logic [CNT_W-1:0]   cnt_q;
	logic [REM_W-1:0]   dsh;
	logic [IDX_W-1:0]   idx [2];
	logic [NUM_W-1:0]   nx_d, ny_d;
	logic               accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			bins_q  <= BINS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				CFG_BINS:  bins_q  <= cfg_data[BINS_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_eff = (scale_q == '0) ? SCALE_W'(1) : scale_q;
	assign bins_eff = (bins_q == '0) ? BINS_W'(1) :
		(bins_q > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS) : bins_q;
	assign div_d = {s_eff, 1'b0};
	assign bmax  = IDX_W'(bins_eff - BINS_W'(1));

	assign nx_d = {{2{opinion_x[OPN_W-1]}}, opinion_x} + NUM_W'(s_eff);
	assign ny_d = {{2{opinion_y[OPN_W-1]}}, opinion_y} + NUM_W'(s_eff);
	assign dsh  = REM_W'(div_d) << (CNT_W'(IDX_W - 1) - cnt_q);
	assign accept = in_valid && in_ready;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (neg_q[l]) begin
				idx[l] = '0;
			end else if (hi_q[l] || quo_q[l] > bmax) begin
				idx[l] = bmax;
			end else begin
				idx[l] = quo_q[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= mode_t'(mode);
			num_q[0] <= nx_d;
			num_q[1] <= ny_d;
			row_q    <= (mode_t'(mode) == MODE_READ) ? read_row[IDX_W-1:0] : '0;
			col_q    <= (mode_t'(mode) == MODE_READ) ? read_col[IDX_W-1:0] : '0;
		end
		for (int l = 0; l < 2; l++) begin
			if (state_q == F_MUL) begin
				neg_q[l] <= num_q[l][NUM_W-1];
				hi_q[l]  <= !num_q[l][NUM_W-1] &&
					(num_q[l][OPN_W:0] >= (OPN_W+1)'(div_d));
				rem_q[l] <= REM_W'(num_q[l][OPN_W:0]) * REM_W'(bins_eff);
				quo_q[l] <= '0;
			end else if (state_q == F_DIV) begin
				if (rem_q[l] >= dsh) begin
					rem_q[l] <= rem_q[l] - dsh;
					quo_q[l] <= {quo_q[l][IDX_W-2:0], 1'b1};
				end else begin
					quo_q[l] <= {quo_q[l][IDX_W-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd_valid = 1'b0;
		cmd.op    = op_q;
		cmd.row   = (op_q == MODE_ADD) ? idx[1] : row_q;
		cmd.col   = (op_q == MODE_ADD) ? idx[0] : col_q;
		unique case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (mode_t'(mode) == MODE_ADD) ? F_MUL : F_PUSH;
				end
			end
			F_MUL: state_d = F_DIV;
			F_DIV: begin
				if (cnt_q == CNT_W'(IDX_W - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				cmd_valid = 1'b1;
				if (cmd_ready) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/s2dh_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module s2dh_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	input  s2dh_pkg::cmd_t      push_data,
	output logic                push_ready,
	output logic                pop_valid,
	output s2dh_pkg::cmd_t      pop_data,
	input  wire logic           pop_ready
);

	import s2dh_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          ent_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign push_ready = (cnt_q != CW'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = ent_q[rp_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/s2dh_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module s2dh_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  s2dh_pkg::cmd_t     cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [3:0]         bin_row,
	output logic [3:0]         bin_col,
	output logic [15:0]        bin_count,
	output logic [15:0]        agent_total,
	output logic [16:0]        fraction
);

	import s2dh_pkg::*;

	localparam int STEP_W = $clog2(FRAC_W);
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	bstate_t state_q, state_d;

	cmd_t                   cur_q;
	logic [DEPTH-1:0]       vld_q;
	logic [COUNT_WIDTH-1:0] agent_q;
	logic [COUNT_WIDTH-1:0] cnt_q, agn_q, rem_q;
	logic [FRAC_W-1:0]      nb_q, quo_q;
	logic [STEP_W-1:0]      step_q;

	logic [ADDR_W-1:0]      addr_c;
	logic [COUNT_WIDTH-1:0] rdata, old_c, newc, newa, res_cnt, res_agn;
	logic [COUNT_WIDTH:0]   trial;
	logic                   ge;
	logic                   we;
	logic                   load;

	assign addr_c = {cur_q.row, cur_q.col};
	assign we = (state_q == B_RD) && (cur_q.op == MODE_ADD);

	s2dh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(addr_c),
		.wdata(newc),
		.raddr({cmd.row, cmd.col}),
		.rdata(rdata)
	);

	assign old_c = vld_q[addr_c] ? rdata : '0;
	assign newc  = (old_c == CMAX) ? old_c : old_c + COUNT_WIDTH'(1);
	assign newa  = (agent_q == CMAX) ? agent_q : agent_q + COUNT_WIDTH'(1);

	always_comb begin
		case (cur_q.op)
			MODE_ADD: begin
				res_cnt = newc;
				res_agn = newa;
			end
			MODE_READ: begin
				res_cnt = old_c;
				res_agn = agent_q;
			end
			default: begin
				res_cnt = '0;
				res_agn = '0;
			end
		endcase
	end

	assign trial = {rem_q, nb_q[FRAC_W-1]};
	assign ge    = trial >= {1'b0, agn_q};
	assign load  = (state_q == B_DONE) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			vld_q     <= '0;
			agent_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_RD) begin
				if (cur_q.op == MODE_ADD) begin
					vld_q[addr_c] <= 1'b1;
					agent_q       <= newa;
				end else if (cur_q.op == MODE_CLEAR) begin
					vld_q   <= '0;
					agent_q <= '0;
				end
			end
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && cmd_valid) begin
			cur_q <= cmd;
		end
		if (state_q == B_RD) begin
			cnt_q  <= res_cnt;
			agn_q  <= res_agn;
			rem_q  <= res_cnt >> 1;
			nb_q   <= {res_cnt[0], {(FRAC_W-1){1'b0}}};
			quo_q  <= '0;
			step_q <= '0;
		end else if (state_q == B_DIV) begin
			rem_q  <= ge ? COUNT_WIDTH'(trial - {1'b0, agn_q}) : COUNT_WIDTH'(trial);
			nb_q   <= {nb_q[FRAC_W-2:0], 1'b0};
			quo_q  <= {quo_q[FRAC_W-2:0], ge};
			step_q <= step_q + STEP_W'(1);
		end
		if (load) begin
			bin_row     <= 4'(cur_q.row);
			bin_col     <= 4'(cur_q.col);
			bin_count   <= 16'(cnt_q);
			agent_total <= 16'(agn_q);
			fraction    <= (agn_q == '0) ? '0 : 17'(quo_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = B_RD;
				end
			end
			B_RD: state_d = B_DIV;
			B_DIV: begin
				if (step_q == STEP_W'(FRAC_W - 1)) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (load) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/s2dh_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module s2dh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  bin_row,
	input wire logic [3:0]  bin_col,
	input wire logic [15:0] bin_count,
	input wire logic [15:0] agent_total,
	input wire logic [16:0] fraction
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_row) && $stable(bin_col)
			&& $stable(bin_count) && $stable(agent_total) && $stable(fraction))
		else $error("result beat changed while stalled");

	a_frac_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fraction <= 17'h10000)
		else $error("fraction above one");

	a_count_le_agents: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bin_count <= agent_total)
		else $error("bin count exceeds agent total");

	a_zero_agents: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && agent_total == 16'd0 |-> fraction == 17'd0)
		else $error("nonzero fraction with no agents");

	a_full_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && agent_total != 16'd0 && bin_count == agent_total
			|-> fraction == 17'h10000)
		else $error("full bin does not report one");

endmodule

bind scaled_2d_histogram s2dh_checker u_s2dh_checker (.*);

`default_nettype wire
